@@ hw/rtl/tfpm_pkg.sv @@
package tfpm_pkg;

    localparam int unsigned HOST_W = 17;
    localparam int unsigned BYTE_W = 21;
    localparam int unsigned BIT_W  = 17;

    // Converter codes: full scale for 5 V and 12 V * 10/24, half for 2.5 V.
    localparam logic [7:0] ADC_CODE_FULL = 8'd213;
    localparam logic [7:0] ADC_CODE_HALF = 8'd106;
    localparam logic [7:0] ADC_CODE_ZERO = 8'd0;
    localparam logic [3:0] ADC_IDX_MOTOR = 4'd11;

    typedef enum logic {
        REQ_LINE_CHANGE = 1'b0,
        REQ_ADC_START   = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind         req_type;
        logic [3:0]        port1_dir;
        logic [3:0]        port2_dir;
        logic [3:0]        port3_dir;
        logic [3:0]        port4_dir;
        logic              cmd_line;
        logic              motor_line;
        logic              break_line;
        logic [HOST_W-1:0] host_bit_period;
    } t_req;

    typedef struct packed {
        logic [3:0]        low_nibble_in;
        logic [3:0]        high_nibble_in;
        logic [3:0]        pot_a_high;
        logic [3:0]        pot_b_high;
        logic              trigger_pressed;
        logic              loopback_on;
        logic              audio_on;
        logic [BYTE_W-1:0] byte_period;
        logic [BIT_W-1:0]  bit_period;
        logic [16:0]       ext_clock_period;
    } t_res;

    typedef struct packed {
        logic       load;
        logic [7:0] code;
    } t_adc_upd;

    function automatic logic [BYTE_W-1:0] byte_cycles(input logic [3:0] sel);
        logic [BYTE_W-1:0] v;
        case (sel)
            4'd0:    v = BYTE_W'(11932);
            4'd1:    v = BYTE_W'(5966);
            4'd2:    v = BYTE_W'(2983);
            4'd3:    v = BYTE_W'(1491);
            4'd4:    v = BYTE_W'(746);
            4'd5:    v = BYTE_W'(373);
            4'd6:    v = BYTE_W'(1491);
            4'd8:    v = BYTE_W'(95455);
            4'd9:    v = BYTE_W'(47727);
            4'd10:   v = BYTE_W'(23864);
            4'd11:   v = BYTE_W'(11932);
            4'd12:   v = BYTE_W'(5966);
            4'd13:   v = BYTE_W'(2983);
            4'd14:   v = BYTE_W'(11932);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [BIT_W-1:0] bit_cycles(input logic [3:0] sel);
        logic [BIT_W-1:0] v;
        case (sel)
            4'd0:    v = BIT_W'(746);
            4'd1:    v = BIT_W'(373);
            4'd2:    v = BIT_W'(186);
            4'd3:    v = BIT_W'(93);
            4'd4:    v = BIT_W'(47);
            4'd5:    v = BIT_W'(23);
            4'd6:    v = BIT_W'(93);
            4'd8:    v = BIT_W'(5966);
            4'd9:    v = BIT_W'(2983);
            4'd10:   v = BIT_W'(1491);
            4'd11:   v = BIT_W'(746);
            4'd12:   v = BIT_W'(373);
            4'd13:   v = BIT_W'(186);
            4'd14:   v = BIT_W'(746);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] conv_code(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd11, 4'd12: v = ADC_CODE_FULL;
            4'd13, 4'd14: v = ADC_CODE_HALF;
            default:      v = ADC_CODE_ZERO;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/tfpm_req_if.sv @@
interface tfpm_req_if import tfpm_pkg::*;;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tfpm_res_if.sv @@
interface tfpm_res_if import tfpm_pkg::*;;
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/test_fixture_port_bus_mux.sv @@
// Port and serial-line multiplexer for a four-port joystick test fixture.
//
// i_req (sink): one word per port or line change, or per converter start.
// o_res (source): one result word per request word, in order.
// Both channels move a word at a rising edge with valid and ready high.
//
// Path: a word accepted is registered at the input stage, mapped through the bus
// logic and registered again in the result stage before it shows on o_res.
// Throughput: one word per cycle while the receiver does not stall; the input
// register feeding the result register through one mapping pass sets that figure.
//
// The converter start word latches an 8-bit code that also masks later words
// while the command line is high. Reset (synchronous, active low) clears that
// code to zero and empties both stages.
//
// When the receiver stalls, the result word holds and the input stage keeps
// its word; i_req.ready drops only when both stages are full.
module test_fixture_port_bus_mux import tfpm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfpm_req_if.sink   i_req,
    tfpm_res_if.source o_res
);

    logic       r_s1_valid;
    t_req       r_s1_data;
    logic       r_out_valid;
    t_res       r_out_data;
    logic       n_s1_valid;
    logic       n_out_valid;
    logic       advance;
    logic       take;
    logic [7:0] adc_code;
    t_adc_upd   adc_upd;
    t_res       res_comb;

    always_comb begin
        advance     = !r_out_valid || o_res.ready;
        take        = i_req.valid && i_req.ready;
        n_out_valid = advance ? r_s1_valid : r_out_valid;
        n_s1_valid  = take ? 1'b1 : (advance ? 1'b0 : r_s1_valid);
    end

    assign i_req.ready = !r_s1_valid || advance;

    tfpm_map u_map (
        .i_req      (r_s1_data),
        .i_fire     (r_s1_valid && advance),
        .i_adc_code (adc_code),
        .o_upd      (adc_upd),
        .o_res      (res_comb)
    );

    tfpm_adc u_adc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (adc_upd),
        .o_code  (adc_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_data <= i_req.data;
        end
        if (advance && r_s1_valid) begin
            r_out_data <= res_comb;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && advance) |=> r_out_valid)
        else $error("input stage word lost on advance");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_data)))
        else $error("stalled input stage word changed");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("input blocked with result stage empty");

endmodule

@@ hw/rtl/tfpm_adc.sv @@
module tfpm_adc import tfpm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_adc_upd   i_upd,
    output logic [7:0] o_code
);

    logic [7:0] r_code;
    logic [7:0] n_code;

    always_comb begin
        n_code = i_upd.load ? i_upd.code : r_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= ADC_CODE_ZERO;
        end else begin
            r_code <= n_code;
        end
    end

    assign o_code = r_code;

    a_code_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_code == ADC_CODE_ZERO))
        else $error("adc code not cleared by reset");

    a_code_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd.load |=> $stable(r_code))
        else $error("adc code changed without a load");

endmodule

@@ hw/rtl/tfpm_map.sv @@
module tfpm_map import tfpm_pkg::*; (
    input  t_req       i_req,
    input  logic       i_fire,
    input  logic [7:0] i_adc_code,
    output t_adc_upd   o_upd,
    output t_res       o_res
);

    logic [7:0]        bus;
    logic [7:0]        code_eff;
    logic [7:0]        bus_cmd;
    logic [7:0]        bus_m;
    logic [BYTE_W-1:0] host_x10;
    logic [BYTE_W-1:0] byte_p;
    logic [BIT_W-1:0]  bit_p;

    always_comb begin
        bus = {i_req.port2_dir & i_req.port4_dir, i_req.port1_dir & i_req.port3_dir};

        // Converter code picked by the unmasked low nibble; one entry follows motor.
        o_upd.load = i_fire && (i_req.req_type == REQ_ADC_START);
        if (bus[3:0] == ADC_IDX_MOTOR) begin
            o_upd.code = i_req.motor_line ? ADC_CODE_FULL : ADC_CODE_ZERO;
        end else begin
            o_upd.code = conv_code(bus[3:0]);
        end

        // A start item uses its own fresh code.
        code_eff = (i_req.req_type == REQ_ADC_START) ? o_upd.code : i_adc_code;

        bus_cmd = i_req.cmd_line ? (bus & code_eff) : bus;
        bus_m   = (i_req.motor_line && i_req.break_line)
                ? (bus_cmd & {bus_cmd[3:0], bus_cmd[7:4]}) : bus_cmd;

        host_x10 = {1'b0, i_req.host_bit_period, 3'b000}
                 + {3'b000, i_req.host_bit_period, 1'b0};

        if (bus_m[0]) begin
            byte_p = host_x10;
            bit_p  = i_req.host_bit_period;
        end else begin
            byte_p = byte_cycles(bus_m[7:4]);
            bit_p  = bit_cycles(bus_m[7:4]);
        end

        o_res.low_nibble_in    = bus_m[3:0];
        o_res.high_nibble_in   = bus_m[7:4];
        o_res.pot_a_high       = {bus_m[5], bus_m[1], bus_m[7], bus_m[3]};
        o_res.pot_b_high       = {bus_m[4], bus_m[0], bus_m[6], bus_m[2]};
        o_res.trigger_pressed  = !i_req.motor_line;
        o_res.loopback_on      = bus_m[1];
        o_res.audio_on         = bus_m[2] & i_req.motor_line;
        o_res.byte_period      = byte_p;
        o_res.bit_period       = bit_p;
        o_res.ext_clock_period = byte_p[BYTE_W-1:4];
    end

endmodule
